### rtl/kma_pkg.sv
package kma_pkg;

  localparam int COORD_BITS   = 16;
  localparam int MAX_POINTS   = 65535;
  localparam int CNT_W        = $clog2(MAX_POINTS + 1);
  localparam int SUM_W        = COORD_BITS + CNT_W;
  localparam int SQ_W         = 2 * COORD_BITS;
  localparam int DIST_W       = SQ_W + 1;
  localparam int MC_W         = 16;
  localparam int CLUSTERS_DEF = 4;

  localparam logic [MC_W-1:0] MC_MAX = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    sum_t   sx;
    sum_t   sy;
    cnt_t   cnt;
  } kma_rec_t;

  typedef struct packed {
    logic shift;
    logic wr_x;
    logic wr_y;
    logic add;
  } kma_cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_PICK,
    ST_ASSIGN,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } kma_state_t;

endpackage

### rtl/kmeans_assign_accumulate_core.sv
// Two-dimensional k-means step: assigns points to the nearest centroid and
// accumulates per-cluster sums; a finish item emits the updated centroids.
// Item channel (item_valid/item_ready): kind 0 carries a point, kind 1
// finishes the pass. Result channel (result_valid/result_ready): one
// assignment per point (last set), CLUSTERS centroid results per finish
// (last marks the final one). The user must load centroids through
// cfg_write/cfg_index/cfg_data while the block is idle (not enforced).
// Centroids and accumulators live in a ring of CLUSTERS cells that rotates
// past one distance unit and one shared serial divider.
// Point: ST_DIST rotates the ring once past the distance unit, ST_PICK
// settles the nearest, ST_ASSIGN loads the result and adds to its cluster.
// Finish: each non-empty cluster is divided (one bit of quotient per cycle),
// an empty one keeps its centroid; the pass leaves the accumulators clear.
// One item is in progress at a time; item_ready is high only when idle.
// The result register holds its item while result_ready is low; the block
// waits only when a new result is ready and the register is still full.
// Reset clears centroids, sums and counts to zero and empties the result
// register.
module kmeans_assign_accumulate_core
  import kma_pkg::*;
#(
  parameter int CLUSTERS = CLUSTERS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  logic                            kind,
  input  coord_t                          point_x,
  input  coord_t                          point_y,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic                            result_kind,
  output logic [$clog2(CLUSTERS)-1:0]     cluster,
  output coord_t                          new_x,
  output coord_t                          new_y,
  output logic [MC_W-1:0]                 member_count,
  output logic                            last,
  input  logic                            cfg_write,
  input  logic [$clog2(2*CLUSTERS)-1:0]   cfg_index,
  input  coord_t                          cfg_data
);

  localparam int IDX_W = $clog2(CLUSTERS);
  localparam int CFG_W = $clog2(2 * CLUSTERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLUSTERS - 1);

  kma_state_t state;
  kma_state_t state_next;

  kma_rec_t      recs     [CLUSTERS];
  kma_cell_ctl_t cell_ctl [CLUSTERS];
  kma_rec_t      head;
  kma_rec_t      ret;

  coord_t            px;
  coord_t            py;
  logic [IDX_W-1:0]  step;
  logic              sq_valid;
  logic [IDX_W-1:0]  sq_idx;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_y;
  logic [DIST_W-1:0] best;
  logic [IDX_W-1:0]  best_idx;

  logic              out_free;
  logic              chain_shift;
  logic              add_en;
  logic              div_start;
  logic              load_out;
  logic              accept;

  logic              div_done;
  coord_t            div_qx;
  coord_t            div_qy;

  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic [COORD_BITS-1:0] mag_x;
  logic [COORD_BITS-1:0] mag_y;
  logic [DIST_W-1:0]     dist_sq;

  coord_t            emit_cx;
  coord_t            emit_cy;
  logic [31:0]       cnt_wide;
  logic [MC_W-1:0]   cnt_sat;

  assign head     = recs[0];
  assign out_free = !result_valid || result_ready;
  assign accept   = item_valid && item_ready;

  for (genvar k = 0; k < CLUSTERS; k++) begin : g_cell
    kma_rec_t nbr;
    if (k == CLUSTERS - 1) begin : g_tail
      assign nbr = ret;
    end else begin : g_mid
      assign nbr = recs[k+1];
    end

    assign cell_ctl[k] = '{
      shift: chain_shift,
      wr_x:  cfg_write && (cfg_index == CFG_W'(2 * k)),
      wr_y:  cfg_write && (cfg_index == CFG_W'(2 * k + 1)),
      add:   add_en && (best_idx == IDX_W'(k))
    };

    kma_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl[k]),
      .nbr      (nbr),
      .px       (px),
      .py       (py),
      .cfg_data (cfg_data),
      .rec      (recs[k])
    );
  end

  kma_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .sx    (head.sx),
    .sy    (head.sy),
    .cnt   (head.cnt),
    .done  (div_done),
    .qx    (div_qx),
    .qy    (div_qy)
  );

  assign dx      = {px[COORD_BITS-1], px} - {head.cx[COORD_BITS-1], head.cx};
  assign dy      = {py[COORD_BITS-1], py} - {head.cy[COORD_BITS-1], head.cy};
  assign mag_x   = COORD_BITS'(dx[COORD_BITS] ? ((COORD_BITS+1)'(0) - dx) : dx);
  assign mag_y   = COORD_BITS'(dy[COORD_BITS] ? ((COORD_BITS+1)'(0) - dy) : dy);
  assign dist_sq = DIST_W'(sq_x) + DIST_W'(sq_y);

  assign emit_cx  = (head.cnt == '0) ? head.cx : div_qx;
  assign emit_cy  = (head.cnt == '0) ? head.cy : div_qy;
  assign cnt_wide = 32'(head.cnt);
  assign cnt_sat  = (cnt_wide > 32'(MC_MAX)) ? MC_MAX : cnt_wide[MC_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = kind ? ST_DIV_START : ST_DIST;
        end
      end
      ST_DIST: begin
        if (step == LAST_IDX) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: state_next = ST_ASSIGN;
      ST_ASSIGN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV_START: state_next = (head.cnt == '0) ? ST_EMIT : ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = (step == LAST_IDX) ? ST_IDLE : ST_DIV_START;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready  = 1'b0;
    chain_shift = 1'b0;
    add_en      = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    ret         = head;
    unique case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_DIST: chain_shift = 1'b1;
      ST_ASSIGN: begin
        load_out = out_free;
        add_en   = out_free;
      end
      ST_DIV_START: div_start = (head.cnt != '0);
      ST_EMIT: begin
        load_out    = out_free;
        chain_shift = out_free;
        ret         = '{cx: emit_cx, cy: emit_cy, sx: '0, sy: '0, cnt: '0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sq_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state    <= state_next;
      sq_valid <= (state == ST_DIST);
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px   <= point_x;
      py   <= point_y;
      step <= '0;
    end else if (state == ST_DIST || (state == ST_EMIT && out_free)) begin
      step <= step + IDX_W'(1);
    end

    if (state == ST_DIST) begin
      sq_x   <= SQ_W'(mag_x) * SQ_W'(mag_x);
      sq_y   <= SQ_W'(mag_y) * SQ_W'(mag_y);
      sq_idx <= step;
    end

    if (sq_valid && (sq_idx == '0 || dist_sq < best)) begin
      best     <= dist_sq;
      best_idx <= sq_idx;
    end

    if (load_out) begin
      if (state == ST_ASSIGN) begin
        result_kind  <= 1'b0;
        cluster      <= best_idx;
        new_x        <= '0;
        new_y        <= '0;
        member_count <= '0;
        last         <= 1'b1;
      end else begin
        result_kind  <= 1'b1;
        cluster      <= step;
        new_x        <= emit_cx;
        new_y        <= emit_cy;
        member_count <= cnt_sat;
        last         <= (step == LAST_IDX);
      end
    end
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!result_valid || result_ready))
    else $error("result register overwritten while full");

  a_assign_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_kind) |-> (last && new_x == '0 && new_y == '0
      && member_count == '0))
    else $error("assignment result carries centroid fields");

  a_last_centroid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_kind && last) |-> (cluster == LAST_IDX))
    else $error("last centroid result has wrong cluster index");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished outside its wait state");

  a_pick_after_dist: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) |-> sq_valid && (sq_idx == LAST_IDX))
    else $error("distance sweep ended before the last centroid");

endmodule

### rtl/kma_cell.sv
module kma_cell
  import kma_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  kma_cell_ctl_t ctl,
  input  kma_rec_t      nbr,
  input  coord_t        px,
  input  coord_t        py,
  input  coord_t        cfg_data,
  output kma_rec_t      rec
);

  sum_t px_ext;
  sum_t py_ext;
  logic room;

  assign px_ext = sum_t'(px);
  assign py_ext = sum_t'(py);
  assign room   = rec.cnt < CNT_W'(MAX_POINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec <= '0;
    end else if (ctl.shift) begin
      rec <= nbr;
    end else begin
      if (ctl.wr_x) begin
        rec.cx <= cfg_data;
      end
      if (ctl.wr_y) begin
        rec.cy <= cfg_data;
      end
      if (ctl.add && room) begin
        rec.sx  <= rec.sx + px_ext;
        rec.sy  <= rec.sy + py_ext;
        rec.cnt <= rec.cnt + CNT_W'(1);
      end
    end
  end

endmodule

### rtl/kma_div.sv
module kma_div
  import kma_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  sum_t   sx,
  input  sum_t   sy,
  input  cnt_t   cnt,
  output logic   done,
  output coord_t qx,
  output coord_t qy
);

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic              busy;
  logic [ITER_W-1:0] iter;
  logic [SUM_W-1:0]  ax;
  logic [SUM_W-1:0]  ay;
  logic [CNT_W-1:0]  rx;
  logic [CNT_W-1:0]  ry;
  logic [CNT_W-1:0]  dv;
  logic              nx;
  logic              ny;

  logic [CNT_W:0]    shx;
  logic [CNT_W:0]    shy;
  logic              gex;
  logic              gey;
  logic [SUM_W-1:0]  qx_full;
  logic [SUM_W-1:0]  qy_full;

  assign shx = {rx, ax[SUM_W-1]};
  assign shy = {ry, ay[SUM_W-1]};
  assign gex = shx >= {1'b0, dv};
  assign gey = shy >= {1'b0, dv};

  assign qx_full = nx ? (SUM_W'(0) - ax) : ax;
  assign qy_full = ny ? (SUM_W'(0) - ay) : ay;
  assign qx      = coord_t'(qx_full[COORD_BITS-1:0]);
  assign qy      = coord_t'(qy_full[COORD_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      iter <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        iter <= '0;
      end else if (busy) begin
        iter <= iter + ITER_W'(1);
        if (iter == ITER_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ax <= sx[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sx)) : SUM_W'(sx);
      ay <= sy[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sy)) : SUM_W'(sy);
      nx <= sx[SUM_W-1];
      ny <= sy[SUM_W-1];
      rx <= '0;
      ry <= '0;
      dv <= cnt;
    end else if (busy) begin
      ax <= {ax[SUM_W-2:0], gex};
      ay <= {ay[SUM_W-2:0], gey};
      rx <= CNT_W'(gex ? (shx - {1'b0, dv}) : shx);
      ry <= CNT_W'(gey ? (shy - {1'b0, dv}) : shy);
    end
  end

endmodule
